>>> rtl/medac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// medac_pkg: shared types and constants for the matrix element dot accumulate
// Command format passed from the front end to the execution engine, the
// engine state encoding and the fixed datapath widths.
// ----------------------------------------------------------------------------
package medac_pkg;

    localparam int IDX_W   = 4;
    localparam int DATA_W  = 32;
    localparam int LEN_W   = 5;
    localparam int PROD_W  = 2 * DATA_W;
    // Up to 31 products of magnitude at most 2^62 are summed exactly.
    localparam int ACC_W   = 68;
    localparam int FRAC_W  = 16;
    localparam int RND_W   = ACC_W - FRAC_W;
    localparam int TOT_W   = RND_W + 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);
    localparam logic signed [TOT_W-1:0] SAT_MAX = TOT_W'(64'sh7FFF_FFFF);
    localparam logic signed [TOT_W-1:0] SAT_MIN = -TOT_W'(64'sh8000_0000);

    typedef enum logic [1:0] {
        OPC_WRITE_A = 2'd0,
        OPC_WRITE_B = 2'd1,
        OPC_PROCESS = 2'd2,
        OPC_UNUSED  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CMD_WR_A = 2'd0,
        CMD_WR_B = 2'd1,
        CMD_PROC = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [IDX_W-1:0]   pos;
        logic [DATA_W-1:0]  value;
        logic [LEN_W-1:0]   len;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RUN,
        BK_DRAIN,
        BK_ROUND,
        BK_SAT
    } bk_state_t;

endpackage

>>> rtl/medac_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// medac_ram: generic simple dual port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module medac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

>>> rtl/medac_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// medac_queue: short command queue
// Decouples the request front end from the execution engine.
// ----------------------------------------------------------------------------
module medac_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  medac_pkg::cmd_t push_cmd,
    input  logic            pop,
    output medac_pkg::cmd_t head,
    output logic            not_empty,
    output logic            full
);

    import medac_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (int'(p) == QUEUE_DEPTH - 1)
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (int'(count_reg) == QUEUE_DEPTH);

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/medac_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// medac_front: request decode and classification
// Holds the vector length register, drops requests that have no effect and
// turns the rest into queue commands with the effective dot product length.
// ----------------------------------------------------------------------------
module medac_front #(
    parameter int A_ROWS  = 16,
    parameter int B_ROWS  = 16,
    parameter int VEC_MAX = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [1:0]                          opcode,
    input  logic [medac_pkg::IDX_W-1:0]         row,
    input  logic [medac_pkg::IDX_W-1:0]         col,
    input  logic [medac_pkg::IDX_W-1:0]         pos,
    input  logic [medac_pkg::DATA_W-1:0]        value,
    input  logic                                cfg_we,
    input  logic [medac_pkg::LEN_W-1:0]         cfg_wdata,
    input  logic                                queue_full,
    output logic                                busy,
    output logic                                push,
    output medac_pkg::cmd_t                     push_cmd
);

    import medac_pkg::*;

    logic [LEN_W-1:0] vec_len_reg, vec_len_next;
    logic [LEN_W-1:0] eff_len;
    logic             row_ok, col_ok, pos_ok, keep;

    assign busy = queue_full;

    assign row_ok = (32'(row) < A_ROWS);
    assign col_ok = (32'(col) < B_ROWS);
    assign pos_ok = (32'(pos) < VEC_MAX);

    always_comb
    begin
        vec_len_next = cfg_we ? cfg_wdata : vec_len_reg;
        if (32'(vec_len_reg) > VEC_MAX)
            eff_len = LEN_W'(VEC_MAX);
        else
            eff_len = vec_len_reg;
    end

    always_comb
    begin
        push_cmd.row   = row;
        push_cmd.col   = col;
        push_cmd.pos   = pos;
        push_cmd.value = value;
        push_cmd.len   = '0;
        push_cmd.kind  = CMD_PROC;
        keep           = 1'b0;
        unique case (opcode_t'(opcode))
            OPC_WRITE_A:
            begin
                push_cmd.kind = CMD_WR_A;
                keep          = row_ok && pos_ok;
            end
            OPC_WRITE_B:
            begin
                push_cmd.kind = CMD_WR_B;
                keep          = col_ok && pos_ok;
            end
            OPC_PROCESS:
            begin
                push_cmd.kind = CMD_PROC;
                // An out of range row or column gives an empty dot product.
                push_cmd.len  = (row_ok && col_ok) ? eff_len : '0;
                keep          = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = start && !queue_full && keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_len_reg <= LEN_W'(16);
        end
        else
        begin
            vec_len_reg <= vec_len_next;
        end
    end

endmodule

>>> rtl/medac_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// medac_back: vector stores and multiply-accumulate engine
// Executes queued commands: element writes into the A and B stores, and
// dot products through one pipelined multiply-accumulate with final
// rounding and saturation.
// ----------------------------------------------------------------------------
module medac_back #(
    parameter int A_ROWS  = 16,
    parameter int B_ROWS  = 16,
    parameter int VEC_MAX = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  medac_pkg::cmd_t                 head,
    input  logic                            head_valid,
    output logic                            pop,
    output logic                            done,
    output logic [medac_pkg::DATA_W-1:0]    new_value,
    output logic [medac_pkg::IDX_W-1:0]     out_row,
    output logic [medac_pkg::IDX_W-1:0]     out_col,
    output logic                            saturated
);

    import medac_pkg::*;

    localparam int A_DEPTH = A_ROWS * VEC_MAX;
    localparam int B_DEPTH = B_ROWS * VEC_MAX;
    localparam int A_AW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int B_AW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

    bk_state_t state_reg, state_next;

    // Control decoded from the state.
    logic a_we, b_we, load, issue;

    logic [A_AW-1:0]   a_waddr, a_raddr;
    logic [B_AW-1:0]   b_waddr, b_raddr;
    logic [DATA_W-1:0] a_rdata, b_rdata;

    logic [IDX_W-1:0]         row_reg, row_next;
    logic [IDX_W-1:0]         col_reg, col_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [LEN_W-1:0]         k_reg, k_next;
    logic                     rd_v_reg, rd_v_next;
    logic                     mul_v_reg, mul_v_next;
    logic signed [PROD_W-1:0] mul_reg, mul_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [RND_W-1:0]  rnd_reg, rnd_next;
    logic signed [TOT_W-1:0]  total;

    logic                     done_reg, done_next;
    logic [DATA_W-1:0]        res_reg, res_next;
    logic                     sat_reg, sat_next;

    medac_ram #(
        .WIDTH (DATA_W),
        .DEPTH (A_DEPTH)
    ) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (head.value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    medac_ram #(
        .WIDTH (DATA_W),
        .DEPTH (B_DEPTH)
    ) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (head.value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    assign a_waddr = A_AW'(32'(head.row) * VEC_MAX + 32'(head.pos));
    assign b_waddr = B_AW'(32'(head.col) * VEC_MAX + 32'(head.pos));
    assign a_raddr = A_AW'(32'(row_reg) * VEC_MAX + 32'(k_reg));
    assign b_raddr = B_AW'(32'(col_reg) * VEC_MAX + 32'(k_reg));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head_valid && head.kind == CMD_PROC)
                    state_next = (head.len == '0) ? BK_DRAIN : BK_RUN;
            end
            BK_RUN:
            begin
                if (k_reg == len_reg - LEN_W'(1))
                    state_next = BK_DRAIN;
            end
            BK_DRAIN:
            begin
                if (!rd_v_reg && !mul_v_reg)
                    state_next = BK_ROUND;
            end
            BK_ROUND:
            begin
                state_next = BK_SAT;
            end
            BK_SAT:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        pop   = 1'b0;
        a_we  = 1'b0;
        b_we  = 1'b0;
        load  = 1'b0;
        issue = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop = head_valid;
                if (head_valid)
                begin
                    a_we = (head.kind == CMD_WR_A);
                    b_we = (head.kind == CMD_WR_B);
                    load = (head.kind == CMD_PROC);
                end
            end
            BK_RUN:
            begin
                issue = 1'b1;
            end
            BK_DRAIN, BK_ROUND, BK_SAT:
            begin
                issue = 1'b0;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    // Datapath.
    always_comb
    begin
        row_next   = load ? head.row : row_reg;
        col_next   = load ? head.col : col_reg;
        value_next = load ? $signed(head.value) : value_reg;
        len_next   = load ? head.len : len_reg;
        k_next     = load ? '0 : (issue ? k_reg + LEN_W'(1) : k_reg);

        // Read data arrives in the cycle after the address, the product in the
        // cycle after that.
        rd_v_next  = issue;
        mul_v_next = rd_v_reg;
        mul_next   = $signed(a_rdata) * $signed(b_rdata);

        if (load)
            acc_next = '0;
        else if (mul_v_reg)
            acc_next = acc_reg + ACC_W'(mul_reg);
        else
            acc_next = acc_reg;

        acc_rnd  = acc_reg + ROUND_HALF;
        rnd_next = acc_rnd[ACC_W-1:FRAC_W];

        total     = TOT_W'(value_reg) + TOT_W'(rnd_reg);
        done_next = (state_reg == BK_SAT);
        res_next  = res_reg;
        sat_next  = sat_reg;
        if (state_reg == BK_SAT)
        begin
            if (total > SAT_MAX)
            begin
                res_next = SAT_MAX[DATA_W-1:0];
                sat_next = 1'b1;
            end
            else if (total < SAT_MIN)
            begin
                res_next = SAT_MIN[DATA_W-1:0];
                sat_next = 1'b1;
            end
            else
            begin
                res_next = total[DATA_W-1:0];
                sat_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            rd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= rd_v_next;
            mul_v_reg <= mul_v_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        col_reg   <= col_next;
        value_reg <= value_next;
        len_reg   <= len_next;
        k_reg     <= k_next;
        mul_reg   <= mul_next;
        acc_reg   <= acc_next;
        rnd_reg   <= rnd_next;
        res_reg   <= res_next;
        sat_reg   <= sat_next;
    end

    assign done      = done_reg;
    assign new_value = res_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign saturated = sat_reg;

endmodule

>>> rtl/matrix_element_dot_accumulate_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_element_dot_accumulate_top: C += A * B^T one element at a time
// Loads A and B row vectors element by element and updates one signed
// Q16.16 matrix element per process request, with saturation.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy rises only
// when the two-entry command queue is full. Each result is shown for one
// cycle with done high and cannot be held off, so the receiver must take
// it then. A write request is done once the engine takes the command. For
// a process request the engine takes the command, then the single shared
// multiply-accumulate reads one A and one B element per cycle from the
// vector stores, n elements in all, n being the effective vector length
// (vec_len clamped to VEC_MAX, zero for an out of range row or column);
// then the engine drains the pipeline, rounds and saturates. An empty dot
// product goes straight from taking the command to the drain. Write vec_len
// only while no request is outstanding.
module matrix_element_dot_accumulate_top #(
    parameter int A_ROWS  = 16,
    parameter int B_ROWS  = 16,
    parameter int VEC_MAX = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      opcode,
    input  logic [medac_pkg::IDX_W-1:0]     row,
    input  logic [medac_pkg::IDX_W-1:0]     col,
    input  logic [medac_pkg::IDX_W-1:0]     pos,
    input  logic signed [medac_pkg::DATA_W-1:0] value,
    input  logic                            cfg_we,
    input  logic [medac_pkg::LEN_W-1:0]     cfg_wdata,
    output logic                            done,
    output logic signed [medac_pkg::DATA_W-1:0] new_value,
    output logic [medac_pkg::IDX_W-1:0]     out_row,
    output logic [medac_pkg::IDX_W-1:0]     out_col,
    output logic                            saturated
);

    import medac_pkg::*;

    logic  push, pop, queue_full, queue_not_empty;
    cmd_t  push_cmd, head;
    logic [DATA_W-1:0] new_value_raw;

    medac_front #(
        .A_ROWS  (A_ROWS),
        .B_ROWS  (B_ROWS),
        .VEC_MAX (VEC_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .opcode     (opcode),
        .row        (row),
        .col        (col),
        .pos        (pos),
        .value      (value),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .queue_full (queue_full),
        .busy       (busy),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    medac_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head      (head),
        .not_empty (queue_not_empty),
        .full      (queue_full)
    );

    medac_back #(
        .A_ROWS  (A_ROWS),
        .B_ROWS  (B_ROWS),
        .VEC_MAX (VEC_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (queue_not_empty),
        .pop        (pop),
        .done       (done),
        .new_value  (new_value_raw),
        .out_row    (out_row),
        .out_col    (out_col),
        .saturated  (saturated)
    );

    assign new_value = $signed(new_value_raw);

endmodule
